// ----- rtl/ipc_pkg.sv -----
// shared constants, types and helpers for the isolated pixel check unit
package ipc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // one line store entry: pixel and still-unpaired mark
  typedef struct packed {
    logic unpaired;
    logic pixel;
  } store_entry_t;

  // position flags of one pixel, travel with it to the evaluate stage
  typedef struct packed {
    logic             first_row;
    logic             first_col;
    logic             last_col;
    logic             last_row;
    logic [COL_W-1:0] col;
  } scan_tag_t;

  // line store write request
  typedef struct packed {
    logic         we;
    logic [COL_W-1:0] addr;
    store_entry_t data;
  } wr_req_t;

  // last column index for a width register, 0 acts as 1, large values saturate
  function automatic logic [COL_W-1:0] last_col_idx(input logic [DIM_W-1:0] w);
    logic [DIM_W-1:0] wm1;
    wm1 = w - DIM_W'(1);
    if (w == '0) begin
      return '0;
    end else if (w > DIM_W'(MAX_WIDTH)) begin
      return COL_W'(MAX_WIDTH - 1);
    end else begin
      return wm1[COL_W-1:0];
    end
  endfunction

  // last row index for a height register, same clamping
  function automatic logic [ROW_W-1:0] last_row_idx(input logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] hm1;
    hm1 = h - DIM_W'(1);
    if (h == '0) begin
      return '0;
    end else if (h > DIM_W'(MAX_HEIGHT)) begin
      return ROW_W'(MAX_HEIGHT - 1);
    end else begin
      return hm1[ROW_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/isolated_pixel_check_unit.sv -----
// top level of the streaming 4-connected isolated pixel check
//
//  channel  direction  payload                       transaction when
//  in_      slave      tdata[0] pixel_on             in_tvalid && in_tready
//  out_     master     tdata[0] all_paired           out_tvalid && out_tready
//  cfg_     slave      index, data (11 bit dims)     cfg_valid && cfg_ready
//
// one pixel per clock unless a final pixel stalls; the verdict passes the evaluate stage
// and then the output register, the line store read and its write-back overlap with forwarding
// reset needs no line store pass: the first row of an image ignores what it reads
// while a verdict waits unread, the next image's last pixel holds in_tready low
// a register write restarts the image in progress, the line store is kept
module isolated_pixel_check_unit
  import ipc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // stream in
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] pixel_on, [7:1] zero
  // stream out
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [0] all_paired, [7:1] zero
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic         in_fire;
  logic         restart;
  scan_tag_t    cur_tag;
  store_entry_t rd_data;
  wr_req_t      wr;
  logic         b_stall;
  logic         out_load;
  logic         out_verdict;
  logic         out_busy;
  logic         out_valid_r, out_valid_nxt;
  logic         out_data_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !b_stall;
  assign in_fire   = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;

  ipc_scan_ctrl u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .restart   (restart),
    .cur_tag   (cur_tag)
  );

  ipc_line_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (cur_tag.col),
    .wr      (wr),
    .rd_data (rd_data)
  );

  ipc_pair_eval u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .in_fire     (in_fire),
    .in_pixel    (in_tdata[0]),
    .cur_tag     (cur_tag),
    .rd_data     (rd_data),
    .out_busy    (out_busy),
    .wr          (wr),
    .b_stall     (b_stall),
    .out_load    (out_load),
    .out_verdict (out_verdict)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

endmodule

// ----- rtl/ipc_line_store.sv -----
// per-column line store with registered read and write-to-read forwarding
module ipc_line_store
  import ipc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  wr_req_t          wr,
  output store_entry_t     rd_data
);

  store_entry_t mem [MAX_WIDTH];
  store_entry_t rdata_r;
  store_entry_t fwd_data_r;
  logic         fwd_r;
  logic         fwd_nxt;

  // same entry written and read in one cycle: take the new value
  assign fwd_nxt = wr.we && (wr.addr == rd_addr);

  // write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      fwd_data_r <= wr.data;
    end
  end

  // bypass select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= fwd_nxt;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rdata_r;

  // a colliding read must pick the bypass path
  a_fwd_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && fwd_nxt |=> fwd_r)
    else $error("line store collision not forwarded");

endmodule

// ----- rtl/ipc_scan_ctrl.sv -----
// configuration registers and raster position counters
module ipc_scan_ctrl
  import ipc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_fire,
  output logic                 restart,
  output scan_tag_t            cur_tag
);

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] lim_col;
  logic [ROW_W-1:0] lim_row;

  assign lim_col = last_col_idx(width_r);
  assign lim_row = last_row_idx(height_r);

  // position flags of the pixel now offered
  always_comb begin
    cur_tag.first_row = (row_r == '0);
    cur_tag.first_col = (col_r == '0);
    cur_tag.last_col  = (col_r == lim_col);
    cur_tag.last_row  = (row_r == lim_row);
    cur_tag.col       = col_r;
  end

  // register writes, a write to either defined index restarts the image
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    restart    = 1'b0;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          width_nxt = cfg_data;
          restart   = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          height_nxt = cfg_data;
          restart    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // raster counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (cur_tag.last_col) begin
        col_nxt = '0;
        row_nxt = cur_tag.last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // counters never run past the configured image
  a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= lim_col) && (row_r <= lim_row))
    else $error("raster position outside image");

endmodule

// ----- rtl/ipc_pair_eval.sv -----
// evaluate stage: pairing of each pixel, line store write-back and verdict
module ipc_pair_eval
  import ipc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         restart,
  input  logic         in_fire,
  input  logic         in_pixel,
  input  scan_tag_t    cur_tag,
  input  store_entry_t rd_data,
  input  logic         out_busy,
  output wr_req_t      wr,
  output logic         b_stall,
  output logic         out_load,
  output logic         out_verdict
);

  logic         b_valid_r, b_valid_nxt;
  scan_tag_t    b_tag_r;
  logic         b_pix_r;
  store_entry_t left_r, left_nxt;
  store_entry_t last_r, last_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic         verdict_ok_r, verdict_ok_nxt;

  logic         b_fire;
  store_entry_t up;
  store_entry_t left_mod;
  store_entry_t new_left;
  logic         cur_unp;
  logic         fail_up;
  logic         inc_left;
  logic         inc_cur;
  logic [CNT_W-1:0] cnt_sum;
  logic         verdict_now;

  // final pixel waits here while the previous verdict is still unread
  assign b_stall = b_valid_r && b_tag_r.last_col && b_tag_r.last_row && out_busy;
  assign b_fire  = b_valid_r && !b_stall;

  // upper neighbor: last column lives in a register, the rest in memory
  assign up = b_tag_r.last_col ? last_r : rd_data;

  // pairing of the current pixel with upper and left neighbors
  always_comb begin
    cur_unp  = b_pix_r;
    fail_up  = 1'b0;
    left_mod = left_r;
    if (!b_tag_r.first_row) begin
      if (b_pix_r && up.pixel) begin
        cur_unp = 1'b0;
      end
      fail_up = up.unpaired && !b_pix_r;
    end
    if (!b_tag_r.first_col && b_pix_r && left_r.pixel) begin
      cur_unp           = 1'b0;
      left_mod.unpaired = 1'b0;
    end
    new_left.pixel    = b_pix_r;
    new_left.unpaired = cur_unp;
    inc_left    = !b_tag_r.first_col && left_mod.unpaired;
    inc_cur     = b_tag_r.last_col && cur_unp;
    cnt_sum     = cnt_r + CNT_W'(inc_left) + CNT_W'(inc_cur);
    verdict_now = verdict_ok_r && !fail_up;
  end

  // write-back of the finished left entry
  always_comb begin
    wr.we   = b_fire && !b_tag_r.first_col;
    wr.addr = b_tag_r.col - COL_W'(1);
    wr.data = left_mod;
  end

  // result of the last pixel of an image
  assign out_load    = b_fire && b_tag_r.last_col && b_tag_r.last_row;
  assign out_verdict = verdict_now && (cnt_sum == '0);

  // row and image state update
  always_comb begin
    b_valid_nxt    = in_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_r);
    left_nxt       = left_r;
    last_nxt       = last_r;
    cnt_nxt        = cnt_r;
    verdict_ok_nxt = verdict_ok_r;
    if (restart) begin
      left_nxt       = '0;
      cnt_nxt        = '0;
      verdict_ok_nxt = 1'b1;
    end else if (b_fire) begin
      if (b_tag_r.last_col) begin
        last_nxt = new_left;
        left_nxt = '0;
        cnt_nxt  = '0;
        verdict_ok_nxt = b_tag_r.last_row ? 1'b1 : verdict_now;
      end else begin
        left_nxt       = new_left;
        cnt_nxt        = cnt_sum;
        verdict_ok_nxt = verdict_now;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r    <= 1'b0;
      left_r       <= '0;
      cnt_r        <= '0;
      verdict_ok_r <= 1'b1;
    end else begin
      b_valid_r    <= b_valid_nxt;
      left_r       <= left_nxt;
      cnt_r        <= cnt_nxt;
      verdict_ok_r <= verdict_ok_nxt;
    end
  end

  // payload of the stage and the last-column entry
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_tag_r <= cur_tag;
      b_pix_r <= in_pixel;
    end
    last_r <= last_nxt;
  end

  // a finished image leaves clean row state behind
  a_image_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> verdict_ok_r && (cnt_r == '0) && (left_r == '0))
    else $error("image state not restarted after verdict");

  // a stalled final pixel keeps its place and flags
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    b_stall |=> b_valid_r && $stable(b_tag_r) && $stable(b_pix_r))
    else $error("stalled pixel lost");

endmodule
